[design/rse_pkg.sv]
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, codes and helpers for the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rse_pkg;

  // Payload widths.
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int ERR_W  = 3;

  // Default operand stack depth.
  localparam int RSE_DEPTH = 15;

  // Divider geometry: the dividend is the magnitude shifted up by 16 bits.
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = DATA_W + FRAC_W;
  localparam int STEP_W    = $clog2(DVD_W);
  localparam int PROD_W    = 2 * DATA_W;

  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [ERR_W-1:0]         err_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Token function codes.
  localparam func_t FN_PUSH      = 3'd0;
  localparam func_t FN_ADD       = 3'd1;
  localparam func_t FN_SUB       = 3'd2;
  localparam func_t FN_MUL       = 3'd3;
  localparam func_t FN_DIV       = 3'd4;
  localparam func_t FN_UNKNOWN   = 3'd5;
  localparam func_t FN_MALFORMED = 3'd6;
  localparam func_t FN_FINISH    = 3'd7;

  // Error codes.
  localparam err_t ERR_NONE  = 3'd0;
  localparam err_t ERR_TOKEN = 3'd1;
  localparam err_t ERR_DEPTH = 3'd2;
  localparam err_t ERR_OP    = 3'd3;
  localparam err_t ERR_DIV0  = 3'd4;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic  start;
    func_t op;
  } alu_req_t;

  // Response from the shared arithmetic unit.
  typedef struct packed {
    logic  done;
    data_t result;
  } alu_rsp_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic data_t sat_q(input logic signed [DVD_W-1:0] v);
    logic signed [DVD_W-1:0] hi;
    logic signed [DVD_W-1:0] lo;
    hi = DVD_W'(48'sh0000_7FFF_FFFF);
    lo = -hi - DVD_W'(48'sd1);
    if (v > hi) begin
      return data_t'(hi[DATA_W-1:0]);
    end else if (v < lo) begin
      return data_t'(lo[DATA_W-1:0]);
    end
    return data_t'(v[DATA_W-1:0]);
  endfunction

endpackage

[design/rse_in_if.sv]
// ----------------------------------------------------------------------------
// rse_in_if
// Token channel: classified token with its operand, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rse_in_if import rse_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  data_t operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink   (input valid, input func, input operand, output ready);
endinterface

[design/rse_out_if.sv]
// ----------------------------------------------------------------------------
// rse_out_if
// Result channel: final value, latched error and empty flag.
// ----------------------------------------------------------------------------
interface rse_out_if import rse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  err_t  error_code;
  logic  was_empty;

  modport source (output valid, output value, output error_code, output was_empty,
                  input ready);
  modport sink   (input valid, input value, input error_code, input was_empty,
                  output ready);
endinterface

[design/rse_alu.sv]
// ----------------------------------------------------------------------------
// rse_alu
// Shared Q16.16 arithmetic unit: saturating add and subtract in one step,
// rounded multiply in two steps, restoring divide at one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rse_alu import rse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  input  data_t    a,
  input  data_t    b,
  output alu_rsp_t rsp
);

  localparam logic [1:0] AS_IDLE = 2'd0;
  localparam logic [1:0] AS_MUL  = 2'd1;
  localparam logic [1:0] AS_DIV  = 2'd2;
  localparam logic [1:0] AS_SIGN = 2'd3;

  logic [1:0]               state;
  logic signed [PROD_W-1:0] prod;
  logic [DVD_W-1:0]         dvd;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        divisor;
  logic                     neg;
  logic [STEP_W-1:0]        step;
  logic                     done;
  data_t                    result;

  logic signed [PROD_W-1:0] rounded;
  logic [DATA_W:0]          rem_shift;
  logic                     fits;
  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        mag_b;
  logic signed [DATA_W:0]   sum;

  // Operand magnitudes, add or subtract sum, rounding and one restoring divide step.
  always_comb begin
    mag_a     = a[DATA_W-1] ? (~a + 1'b1) : a;
    mag_b     = b[DATA_W-1] ? (~b + 1'b1) : b;
    rounded   = (prod + PROD_W'(64'sd32768)) >>> FRAC_W;
    rem_shift = {rem, dvd[DVD_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
    if (req.op == FN_SUB) begin
      sum = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
  end

  // Completion flag: raised in the cycle after an add or subtract starts, and at the
  // end of the multiply and divide sequences.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == AS_IDLE && req.start && req.op != FN_MUL && req.op != FN_DIV) ||
              (state == AS_MUL) || (state == AS_SIGN);
    end
  end

  // Sequencer of the shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      case (state)
        AS_IDLE: begin
          if (req.start) begin
            case (req.op)
              FN_MUL: begin
                prod  <= a * b;
                state <= AS_MUL;
              end
              FN_DIV: begin
                dvd     <= {mag_a, {FRAC_W{1'b0}}};
                divisor <= mag_b;
                rem     <= '0;
                neg     <= a[DATA_W-1] ^ b[DATA_W-1];
                step    <= '0;
                state   <= AS_DIV;
              end
              default: begin
                result <= sat_q(DVD_W'(sum));
              end
            endcase
          end
        end
        AS_MUL: begin
          result <= sat_q(rounded[DVD_W-1:0]);
          state  <= AS_IDLE;
        end
        AS_DIV: begin
          if (fits) begin
            rem <= DATA_W'(rem_shift - {1'b0, divisor});
          end else begin
            rem <= rem_shift[DATA_W-1:0];
          end
          dvd  <= {dvd[DVD_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(DVD_W - 1)) begin
            state <= AS_SIGN;
          end
        end
        AS_SIGN: begin
          // Apply the quotient sign and clamp to the 32-bit range.
          if (neg) begin
            if (dvd > DVD_W'(48'h0000_8000_0000)) begin
              result <= data_t'(32'h8000_0000);
            end else begin
              result <= data_t'(~dvd[DATA_W-1:0] + 1'b1);
            end
          end else begin
            if (dvd > DVD_W'(48'h0000_7FFF_FFFF)) begin
              result <= data_t'(32'h7FFF_FFFF);
            end else begin
              result <= data_t'(dvd[DATA_W-1:0]);
            end
          end
          state <= AS_IDLE;
        end
        default: begin
          state <= AS_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

[design/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator over pre-classified tokens, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens arrive on the tokens channel (func, operand) with valid/ready; a
//   transfer happens when both are high. Each finish token produces one
//   transfer on the results channel carrying the popped value, the latched
//   error code and an empty flag; no other token produces a result.
//   One token is processed at a time; tokens.ready is high only between tokens.
//   Divide uses the shared restoring divider, which produces one of 48
//   quotient bits per cycle. A depth error is found as soon as the operator
//   token is accepted; an unknown operator or a divide by zero is found once
//   both operands are read. Operands live in a DEPTH-entry memory with one
//   write and one registered read port; operators read their two entries in
//   the LOAD_B and LOAD_A states.
//   Reset empties the stack and clears the error; stack contents are not
//   cleared. The result register parts the two sides: a stalled receiver
//   blocks only the next finish token, which waits until the slot frees.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator import rse_pkg::*; #(
  parameter int DEPTH = RSE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  rse_in_if.sink    tokens,
  rse_out_if.source results
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD_B = 3'd1;
  localparam logic [2:0] ST_LOAD_A = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] depth;
  err_t             err;
  func_t            func_q;
  data_t            op_b;

  data_t            mem [DEPTH];
  data_t            rd_data;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  data_t            wdata;
  logic             we;

  logic             out_valid;
  data_t            out_value;
  err_t             out_err;
  logic             out_empty;

  logic             accept;
  logic             room;
  logic             depth_ok;
  logic             fin_load;
  logic [CNT_W-1:0] depth_m1;
  logic [CNT_W-1:0] depth_m2;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // Handshake and stack bookkeeping.
  always_comb begin
    accept   = tokens.valid && tokens.ready;
    depth_m1 = depth - CNT_W'(1);
    depth_m2 = depth - CNT_W'(2);
    room     = depth < CNT_W'(DEPTH);
    depth_ok = (depth >= CNT_W'(2)) && room;
    fin_load = (state == ST_FIN) && (!out_valid || results.ready);
    raddr    = (state == ST_LOAD_B) ? depth_m2[IDX_W-1:0] : depth_m1[IDX_W-1:0];
  end

  // Memory write port: operand pushes and arithmetic results.
  always_comb begin
    we    = 1'b0;
    waddr = depth[IDX_W-1:0];
    wdata = tokens.operand;
    if (state == ST_IDLE && accept && tokens.func == FN_PUSH && room) begin
      we = 1'b1;
    end else if (state == ST_RUN && alu_rsp.done) begin
      we    = 1'b1;
      waddr = depth_m2[IDX_W-1:0];
      wdata = alu_rsp.result;
    end
  end

  // Operand stack storage with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Start the shared unit once both operands are in hand.
  always_comb begin
    alu_req.op    = func_q;
    alu_req.start = (state == ST_LOAD_A) && (func_q != FN_UNKNOWN) &&
                    !(func_q == FN_DIV && op_b == '0);
  end

  rse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (rd_data),
    .b   (op_b),
    .rsp (alu_rsp)
  );

  // Token sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      depth <= '0;
      err   <= ERR_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (tokens.func)
              FN_PUSH: begin
                if (room) begin
                  depth <= depth + CNT_W'(1);
                end
              end
              FN_MALFORMED: begin
                err <= ERR_TOKEN;
              end
              FN_FINISH: begin
                state <= ST_FIN;
              end
              default: begin
                if (depth_ok) begin
                  func_q <= tokens.func;
                  state  <= ST_LOAD_B;
                end else begin
                  err <= ERR_DEPTH;
                end
              end
            endcase
          end
        end
        ST_LOAD_B: begin
          op_b  <= rd_data;
          state <= ST_LOAD_A;
        end
        ST_LOAD_A: begin
          if (func_q == FN_UNKNOWN) begin
            err   <= ERR_OP;
            depth <= depth_m2;
            state <= ST_IDLE;
          end else if (func_q == FN_DIV && op_b == '0) begin
            err   <= ERR_DIV0;
            depth <= depth_m2;
            state <= ST_IDLE;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (alu_rsp.done) begin
            depth <= depth_m1;
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            depth <= '0;
            err   <= ERR_NONE;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_value <= (depth == '0) ? data_t'(0) : rd_data;
      out_err   <= err;
      out_empty <= (depth == '0);
    end
  end

  assign tokens.ready       = (state == ST_IDLE);
  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.error_code = out_err;
  assign results.was_empty  = out_empty;

  // The stack never holds more entries than it has room for.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(DEPTH))
    else $error("stack depth beyond capacity");

  // The shared unit only reports completion while an operator waits on it.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == ST_RUN)
    else $error("arithmetic completion outside of an operator");

  // Loading a result empties the stack and clears the error.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> (depth == '0 && err == ERR_NONE && out_valid))
    else $error("finish did not clear the block");

  // A push with room grows the stack by exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && tokens.func == FN_PUSH && room) |=> depth == $past(depth) + CNT_W'(1))
    else $error("push did not grow the stack");

endmodule
